@@ rtl/pip_pkg.sv @@
// Shared types and constants of the point-in-polygon test block.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int COUNT_W = 7;
    localparam int APB_AW  = 2;
    localparam int APB_DW  = 32;

    localparam logic [APB_AW-1:0] REG_VERTEX_COUNT = APB_AW'(0);

    // Edge tolerance, about 1e-8 square metres at Q32.32
    localparam logic signed [ACC_W-1:0] ONEDGE_TOL = ACC_W'(43);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [5:0]                vertex_index;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_z;
    } t_item;

    typedef struct packed {
        logic inside_res;
        logic on_edge;
    } t_result;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] z;
    } t_vertex;

    // Product sequence of one edge; each step also picks its accumulator
    typedef enum logic [2:0] {
        MUL_CR_A,   // abx * apz
        MUL_CR_B,   // abz * apx
        MUL_DOT_A,  // apx * abx
        MUL_DOT_B,  // apz * abz
        MUL_LEN_A,  // abx * abx
        MUL_LEN_B   // abz * abz
    } t_mul_sel;

    typedef struct packed {
        logic     p_load;
        logic     a_load;
        logic     diff_en;
        logic     mul_en;
        t_mul_sel mul_sel;
    } t_eu_ctrl;

    typedef struct packed {
        logic on_edge;
        logic hit;
    } t_eu_stat;

endpackage

`default_nettype wire

@@ rtl/pip_vertex_mem.sv @@
// Vertex store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pip_vertex_mem
    import pip_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_vertex       i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_vertex            o_rdata
);

    t_vertex r_mem [DEPTH];
    t_vertex r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/pip_edge_unit.sv @@
// Edge test datapath: differences, one shared multiplier and three accumulators.
`timescale 1ns / 1ps
`default_nettype none

module pip_edge_unit
    import pip_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_eu_ctrl i_ctrl,
    input  wire t_vertex  i_point,
    input  wire t_vertex  i_vtx,
    output t_eu_stat      o_stat
);

    logic signed [COORD_W-1:0] r_px, r_pz, r_ax, r_az;
    logic signed [DIFF_W-1:0]  r_abx, r_abz, r_apx, r_apz;
    logic                      r_straddle, r_b_above;
    logic signed [DIFF_W-1:0]  w_op_a, w_op_b;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_pvalid;
    t_mul_sel                  r_psel;
    logic signed [ACC_W-1:0]   w_pext;
    logic signed [ACC_W-1:0]   r_cross, r_dot, r_len;

    // Operand select for the shared multiplier
    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_CR_A:  begin w_op_a = r_abx; w_op_b = r_apz; end
            MUL_CR_B:  begin w_op_a = r_abz; w_op_b = r_apx; end
            MUL_DOT_A: begin w_op_a = r_apx; w_op_b = r_abx; end
            MUL_DOT_B: begin w_op_a = r_apz; w_op_b = r_abz; end
            MUL_LEN_A: begin w_op_a = r_abx; w_op_b = r_abx; end
            MUL_LEN_B: begin w_op_a = r_abz; w_op_b = r_abz; end
            default:   begin w_op_a = r_abx; w_op_b = r_abx; end
        endcase
    end

    assign w_pext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.p_load) begin
            r_px <= i_point.x;
            r_pz <= i_point.z;
        end
        if (i_ctrl.a_load) begin
            r_ax <= i_vtx.x;
            r_az <= i_vtx.z;
        end
        if (i_ctrl.diff_en) begin
            r_abx      <= DIFF_W'(i_vtx.x) - DIFF_W'(r_ax);
            r_abz      <= DIFF_W'(i_vtx.z) - DIFF_W'(r_az);
            r_apx      <= DIFF_W'(r_px) - DIFF_W'(r_ax);
            r_apz      <= DIFF_W'(r_pz) - DIFF_W'(r_az);
            r_straddle <= (r_az > r_pz) != (i_vtx.z > r_pz);
            r_b_above  <= i_vtx.z > r_pz;
            // Advance: this edge's end is the next edge's start
            r_ax       <= i_vtx.x;
            r_az       <= i_vtx.z;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= PROD_W'(w_op_a) * PROD_W'(w_op_b);
            r_psel <= i_ctrl.mul_sel;
        end
        if (r_pvalid) begin
            case (r_psel)
                MUL_CR_A:  r_cross <= w_pext;
                MUL_CR_B:  r_cross <= r_cross - w_pext;
                MUL_DOT_A: r_dot   <= w_pext;
                MUL_DOT_B: r_dot   <= r_dot + w_pext;
                MUL_LEN_A: r_len   <= w_pext + ONEDGE_TOL;
                MUL_LEN_B: r_len   <= r_len + w_pext;
                default:   r_len   <= r_len;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_ctrl.mul_en;
        end
    end

    // Crossing: cross > 0 means px - ax < crossing offset when b lies above
    assign o_stat.on_edge = (r_cross <= ONEDGE_TOL) && (r_cross >= -ONEDGE_TOL)
                            && (r_dot >= -ONEDGE_TOL) && (r_dot <= r_len);
    assign o_stat.hit     = r_straddle
                            && (r_b_above ? (r_cross > ACC_W'(0)) : (r_cross < ACC_W'(0)));

endmodule

`default_nettype wire

@@ rtl/point_in_polygon_test_top.sv @@
// Point-in-polygon test: vertex store, edge sequencer and register port.
// A vertex write gives no result.
// A query over n stored vertices runs each edge on the one shared multiplier as
// difference, six products, drain and evaluate; an empty polygon strobes its result
// directly from idle, and an on-edge hit ends early.
// One item at a time; busy is high until the result strobe. The result cannot be stalled.
// Synchronous active-low reset clears the sequencer and vertex_count; vertex slots stay unset.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test_top
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_item             i_item,
    output logic                   o_result_valid,
    output t_result                o_result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_A,
        S_DIFF,
        S_MUL,
        S_DRAIN,
        S_EVAL
    } t_state;

    t_state               r_state;
    logic [COUNT_W-1:0]   r_count;
    logic [CW-1:0]        r_idx, r_last;
    logic [2:0]           r_step;
    logic                 r_inside;
    logic                 r_result_valid;
    t_result              r_result;

    logic                 w_accept, w_query, w_wr_ok;
    logic [CW-1:0]        w_n, w_last, w_idx_next;
    logic [AW-1:0]        w_raddr;
    t_vertex              w_wdata, w_point, w_rdata;
    t_eu_ctrl             w_ctrl;
    t_eu_stat             w_stat;

    // Register port
    assign pready = 1'b1;
    assign prdata = APB_DW'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (psel && penable && pwrite && pready && paddr == REG_VERTEX_COUNT) begin
            r_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign busy     = r_state != S_IDLE;
    assign w_accept = start && !busy;
    assign w_query  = w_accept && i_item.mode == MODE_QUERY;
    assign w_wr_ok  = w_accept && i_item.mode == MODE_WRITE
                      && 32'(i_item.vertex_index) < MAX_VERTICES;

    // Saturate the vertex count at the store capacity
    assign w_n        = (32'(r_count) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(r_count);
    assign w_last     = w_n - 1'b1;
    assign w_idx_next = r_idx + 1'b1;

    always_comb begin
        case (r_state)
            S_IDLE:  w_raddr = w_last[AW-1:0];
            S_LD_A:  w_raddr = '0;
            S_EVAL:  w_raddr = w_idx_next[AW-1:0];
            default: w_raddr = r_idx[AW-1:0];
        endcase
    end

    assign w_wdata.x = i_item.coord_x;
    assign w_wdata.z = i_item.coord_z;
    assign w_point   = w_wdata;

    assign w_ctrl.p_load  = w_query;
    assign w_ctrl.a_load  = r_state == S_LD_A;
    assign w_ctrl.diff_en = r_state == S_DIFF;
    assign w_ctrl.mul_en  = r_state == S_MUL;
    assign w_ctrl.mul_sel = t_mul_sel'(r_step);

    pip_vertex_mem #(
        .DEPTH (MAX_VERTICES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_wr_ok),
        .i_waddr (AW'(i_item.vertex_index)),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pip_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_point (w_point),
        .i_vtx   (w_rdata),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_result_valid <= 1'b0;
            r_idx          <= '0;
            r_last         <= '0;
            r_step         <= '0;
            r_inside       <= 1'b0;
        end else begin
            r_result_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_query) begin
                        r_idx    <= '0;
                        r_last   <= w_last;
                        r_inside <= 1'b0;
                        if (w_n == '0) begin
                            r_result_valid      <= 1'b1;
                            r_result.inside_res <= 1'b0;
                            r_result.on_edge    <= 1'b0;
                        end else begin
                            r_state <= S_LD_A;
                        end
                    end
                end
                S_LD_A: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 3'(MUL_LEN_B)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (w_stat.on_edge) begin
                        r_result_valid      <= 1'b1;
                        r_result.inside_res <= 1'b1;
                        r_result.on_edge    <= 1'b1;
                        r_state             <= S_IDLE;
                    end else if (r_idx == r_last) begin
                        r_result_valid      <= 1'b1;
                        r_result.inside_res <= r_inside ^ w_stat.hit;
                        r_result.on_edge    <= 1'b0;
                        r_state             <= S_IDLE;
                    end else begin
                        r_inside <= r_inside ^ w_stat.hit;
                        r_idx    <= w_idx_next;
                        r_state  <= S_DIFF;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for the point-in-polygon block: vertex loads, point queries and count settings.
`timescale 1ns / 1ps
`default_nettype none

module testbench
    import pip_pkg::*;
();

    localparam int VERTEX_SLOTS   = 64;
    localparam int ITEM_TARGET    = 1900;
    localparam int TIMEOUT_CYCLES = 5_000_000;
    localparam int END_WAIT       = 600;
    localparam int WRITE_SETTLE   = 4;
    localparam int ONEDGE_SLACK   = 43;
    localparam int METRE          = 65536;
    localparam int TEN_M          = 10 * METRE;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        SCALE_TINY,
        SCALE_METRE,
        SCALE_FULL
    } t_scale;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    t_item             i_item  = '0;
    logic              o_result_valid;
    t_result           o_result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Block state as the predictor sees it
    logic signed [31:0] poly_x [VERTEX_SLOTS];
    logic signed [31:0] poly_z [VERTEX_SLOTS];
    logic [6:0]         poly_count = '0;

    // Polygon as the stimulus generator last queued it
    logic signed [31:0] shape_x [VERTEX_SLOTS];
    logic signed [31:0] shape_z [VERTEX_SLOTS];
    int                 shape_n = 0;
    t_scale             shape_scale = SCALE_METRE;

    t_item   pending_items[$];
    t_result verdicts_due[$];
    t_result seen_verdict;
    int      idle_pct     = 0;
    int      phase_idx    = 0;
    int      items_queued = 0;
    int      fail_count   = 0;
    int      cycle_count  = 0;

    point_in_polygon_test_top #(
        .MAX_VERTICES(VERTEX_SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit report_failure();
        fail_count++;
        return fail_count <= 10;
    endfunction

    // Even-odd ray cast with boundary test, exact at 72 bits
    function automatic t_result locate_point(input logic signed [31:0] px,
                                             input logic signed [31:0] pz);
        t_result            res;
        int                 n, i, j;
        bit                 odd;
        logic signed [71:0] ax, az, bx, bz, qx, qz, abx, abz, apx, apz;
        logic signed [71:0] cross_v, dot_v, len_v, dz, lhs, rhs, tol;
        res = '0;
        odd = 1'b0;
        tol = 72'(ONEDGE_SLACK);
        n   = (int'(poly_count) > VERTEX_SLOTS) ? VERTEX_SLOTS : int'(poly_count);
        qx  = 72'(px);
        qz  = 72'(pz);
        j   = n - 1;
        for (i = 0; i < n; i++) begin
            ax  = 72'(poly_x[j]);
            az  = 72'(poly_z[j]);
            bx  = 72'(poly_x[i]);
            bz  = 72'(poly_z[i]);
            abx = bx - ax;
            abz = bz - az;
            apx = qx - ax;
            apz = qz - az;
            cross_v = abx * apz - abz * apx;
            dot_v   = apx * abx + apz * abz;
            len_v   = abx * abx + abz * abz;
            if (cross_v <= tol && cross_v >= -tol
                && dot_v >= -tol && dot_v <= len_v + tol) begin
                res.inside_res = 1'b1;
                res.on_edge    = 1'b1;
                return res;
            end
            if ((az > qz) != (bz > qz)) begin
                dz  = bz - az;
                lhs = apx * dz;
                rhs = abx * apz;
                // compare against the crossing x without dividing
                if (dz > 0 ? lhs < rhs : rhs < lhs) begin
                    odd = ~odd;
                end
            end
            j = i;
        end
        res.inside_res = odd;
        return res;
    endfunction

    // Driver: hold start until the transaction is taken, then advance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                void'(pending_items.pop_front());
                if (i_item.mode == MODE_WRITE) begin
                    if (int'(i_item.vertex_index) < VERTEX_SLOTS) begin
                        poly_x[i_item.vertex_index] = i_item.coord_x;
                        poly_z[i_item.vertex_index] = i_item.coord_z;
                    end
                end else begin
                    verdicts_due = {verdicts_due,
                                    locate_point(i_item.coord_x, i_item.coord_z)};
                end
            end
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_item <= pending_items[0];
                start  <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (verdicts_due.size() == 0) begin
                if (report_failure()) begin
                    $display("unexpected result: expected none, got inside=%0b on_edge=%0b",
                             o_result.inside_res, o_result.on_edge);
                end
            end else begin
                seen_verdict = verdicts_due.pop_front();
                if (o_result.inside_res !== seen_verdict.inside_res ||
                    o_result.on_edge !== seen_verdict.on_edge) begin
                    if (report_failure()) begin
                        $display("mismatch: exp inside=%0b on_edge=%0b, got inside=%0b on_edge=%0b",
                                 seen_verdict.inside_res, seen_verdict.on_edge,
                                 o_result.inside_res, o_result.on_edge);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == TIMEOUT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Write the count register, read it back, and return at a falling edge
    task automatic set_vertex_count(input logic [6:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_VERTEX_COUNT;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        poly_count = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(value)) begin
            if (report_failure()) begin
                $display("vertex_count readback: expected %0d, got %0d", value, prdata);
            end
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_write(input int slot, input logic signed [31:0] x,
                               input logic signed [31:0] z);
        t_item cmd;
        cmd.mode         = MODE_WRITE;
        cmd.vertex_index = 6'(slot);
        cmd.coord_x      = x;
        cmd.coord_z      = z;
        pending_items = {pending_items, cmd};
        shape_x[slot] = x;
        shape_z[slot] = z;
        items_queued++;
    endtask

    task automatic queue_query(input logic signed [31:0] x, input logic signed [31:0] z);
        t_item cmd;
        cmd.mode         = MODE_QUERY;
        cmd.vertex_index = 6'($urandom);
        cmd.coord_x      = x;
        cmd.coord_z      = z;
        pending_items = {pending_items, cmd};
        items_queued++;
    endtask

    function automatic logic signed [31:0] pick_coord();
        case (shape_scale)
            SCALE_TINY: return 32'(int'($urandom_range(128)) - 64);
            SCALE_METRE: begin
                if ($urandom_range(3) == 0) begin
                    return 32'((int'($urandom_range(200)) - 100) * METRE
                               + int'($urandom_range(METRE - 1)));
                end
                return 32'((int'($urandom_range(200)) - 100) * METRE);
            end
            default: begin
                case ($urandom_range(9))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    default: return 32'($urandom);
                endcase
            end
        endcase
    endfunction

    // Query points, random or aimed at vertices, edges, chords and vertex heights
    task automatic queue_probe();
        int                 a, b, c;
        logic signed [31:0] px, pz;
        if (shape_n == 0) begin
            queue_query(32'($urandom), 32'($urandom));
            return;
        end
        a = $urandom_range(shape_n - 1);
        b = (a == 0) ? shape_n - 1 : a - 1;
        c = $urandom_range(shape_n - 1);
        case ($urandom_range(9))
            0, 1, 2: begin
                px = pick_coord();
                pz = pick_coord();
            end
            3: begin
                px = shape_x[a];
                pz = shape_z[a];
            end
            4, 5: begin
                px = 32'((longint'(shape_x[a]) + longint'(shape_x[b])) >>> 1);
                pz = 32'((longint'(shape_z[a]) + longint'(shape_z[b])) >>> 1);
                if ($urandom_range(1) == 1) begin
                    pz = pz + 32'(int'($urandom_range(4)) - 2);
                end
            end
            6: begin
                px = pick_coord();
                pz = shape_z[a];
            end
            7: begin
                px = 32'($urandom);
                pz = 32'($urandom);
            end
            default: begin
                px = 32'((longint'(shape_x[a]) + longint'(shape_x[c])) >>> 1);
                pz = 32'((longint'(shape_z[a]) + longint'(shape_z[c])) >>> 1);
            end
        endcase
        queue_query(px, pz);
    endtask

    // Drain, let a trailing vertex write land, then move to the next idling mode
    task automatic finish_phase();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || start || verdicts_due.size() != 0 || busy);
        repeat (WRITE_SETTLE) @(posedge i_clk);
        phase_idx++;
        case (phase_idx % 4)
            1:       idle_pct = 61;
            3:       idle_pct = 28;
            default: idle_pct = 0;
        endcase
    endtask

    task automatic run_random_phase(input int count_value);
        int nn, q, k;
        nn = (count_value > VERTEX_SLOTS) ? VERTEX_SLOTS : count_value;
        shape_scale = t_scale'($urandom_range(2));
        set_vertex_count(7'(count_value));
        for (k = 0; k < nn; k++) begin
            // a repeated vertex makes a zero-length edge
            if (k > 0 && $urandom_range(19) == 0) begin
                queue_write(k, shape_x[k-1], shape_z[k-1]);
            end else begin
                queue_write(k, pick_coord(), pick_coord());
            end
        end
        shape_n = nn;
        q = (nn > 24) ? $urandom_range(3, 8) : $urandom_range(6, 30);
        for (k = 0; k < q; k++) begin
            if ($urandom_range(9) == 0) begin
                queue_write($urandom_range(VERTEX_SLOTS - 1), pick_coord(), pick_coord());
            end else begin
                queue_probe();
            end
        end
        finish_phase();
    endtask

    initial begin
        int r, cnt;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty polygon
        set_vertex_count(0);
        queue_query(0, 0);
        queue_query(COORD_MAX, COORD_MIN);
        finish_phase();

        // single vertex: its only edge is degenerate
        set_vertex_count(1);
        queue_write(0, COORD_MAX, COORD_MIN);
        queue_query(COORD_MIN, COORD_MAX);
        queue_query(0, 0);
        finish_phase();

        // 20 m square around the origin
        set_vertex_count(4);
        queue_write(0, -TEN_M, -TEN_M);
        queue_write(1, TEN_M, -TEN_M);
        queue_write(2, TEN_M, TEN_M);
        queue_write(3, -TEN_M, TEN_M);
        queue_query(0, 0);
        queue_query(2 * TEN_M, 0);
        queue_query(TEN_M, TEN_M);
        queue_query(0, -TEN_M);
        queue_query(0, -TEN_M + 1);
        queue_query(-2 * TEN_M, TEN_M);
        queue_query(-2 * TEN_M, 0);
        finish_phase();

        // triangle spanning the full coordinate range
        set_vertex_count(3);
        queue_write(0, COORD_MIN, COORD_MIN);
        queue_write(1, COORD_MAX, COORD_MIN);
        queue_write(2, 0, COORD_MAX);
        queue_query(0, 0);
        queue_query(COORD_MAX, COORD_MAX);
        queue_query(0, COORD_MIN);
        finish_phase();

        // count above capacity saturates
        run_random_phase(127);
        while (items_queued < ITEM_TARGET) begin
            r = $urandom_range(99);
            if (r < 4) begin
                cnt = 0;
            end else if (r < 10) begin
                cnt = 1;
            end else if (r < 14) begin
                cnt = 2;
            end else if (r < 80) begin
                cnt = $urandom_range(3, 10);
            end else if (r < 92) begin
                cnt = $urandom_range(11, 24);
            end else if (r < 96) begin
                cnt = VERTEX_SLOTS;
            end else begin
                cnt = $urandom_range(VERTEX_SLOTS + 1, 127);
            end
            run_random_phase(cnt);
        end

        repeat (END_WAIT) @(posedge i_clk);
        if (fail_count == 0 && verdicts_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
